// ===== design/shasmd_pkg.sv =====
`default_nettype none
package shasmd_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned HALF_W  = 64;
  localparam int unsigned RND_W   = 6;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [RND_W-1:0] RND_LAST = RND_W'(63);

  localparam logic [CFG_IDX_W-1:0] REG_SECRET_UPPER = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SECRET_LOWER = CFG_IDX_W'(1);

  // padding words of the single 512-bit block
  localparam logic [WORD_W-1:0] PAD_ONE   = 32'h8000_0000;
  localparam logic [WORD_W-1:0] PAD_ZERO  = 32'h0000_0000;
  localparam logic [WORD_W-1:0] PAD_LEN   = 32'h0000_0100;

  localparam logic [WORD_W-1:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL
  } state_t;

  typedef struct packed {
    logic             load;
    logic             round;
    logic             finish;
    logic [RND_W-1:0] rnd;
  } cmd_t;

  function automatic logic [WORD_W-1:0] round_k(input logic [RND_W-1:0] idx);
    logic [WORD_W-1:0] k;
    unique case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== design/shasmd_ctrl.sv =====
`default_nettype none
module shasmd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output shasmd_pkg::cmd_t       cmd
);

  shasmd_pkg::state_t              state_r, state_nxt;
  logic [shasmd_pkg::RND_W-1:0]    rnd_r, rnd_nxt;
  logic                            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= shasmd_pkg::ST_IDLE;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    rnd_nxt    = rnd_r;
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.round  = 1'b0;
    cmd.finish = 1'b0;
    cmd.rnd    = rnd_r;
    unique case (state_r)
      shasmd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          rnd_nxt   = '0;
          state_nxt = shasmd_pkg::ST_ROUND;
        end
      end
      shasmd_pkg::ST_ROUND: begin
        cmd.round = 1'b1;
        rnd_nxt   = rnd_r + 1'b1;
        if (rnd_r == shasmd_pkg::RND_LAST) begin
          state_nxt = shasmd_pkg::ST_FINAL;
        end
      end
      shasmd_pkg::ST_FINAL: begin
        // hold until the output register is free or being drained
        if (!out_valid_r || out_ready) begin
          cmd.finish = 1'b1;
          state_nxt  = shasmd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = shasmd_pkg::ST_IDLE;
      end
    endcase
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  a_start_round0: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == shasmd_pkg::ST_ROUND && rnd_r == '0))
    else $error("round sequence did not start at round zero");

  a_last_round: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == shasmd_pkg::ST_ROUND && rnd_r == shasmd_pkg::RND_LAST)
      |=> state_r == shasmd_pkg::ST_FINAL)
    else $error("missed final add after last round");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_ready))
    else $error("digest overwritten before transaction completed");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.finish))
    else $error("output valid raised without a finished digest");

endmodule
`default_nettype wire

// ===== design/shasmd_datapath.sv =====
`default_nettype none
module shasmd_datapath (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire shasmd_pkg::cmd_t                     cmd,
  input  wire logic                                 cfg_we,
  input  wire logic [shasmd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [shasmd_pkg::HALF_W-1:0]        cfg_data,
  input  wire logic [shasmd_pkg::HALF_W-1:0]        message_upper,
  input  wire logic [shasmd_pkg::HALF_W-1:0]        message_lower,
  output logic [shasmd_pkg::HALF_W-1:0]             digest_word0,
  output logic [shasmd_pkg::HALF_W-1:0]             digest_word1,
  output logic [shasmd_pkg::HALF_W-1:0]             digest_word2,
  output logic [shasmd_pkg::HALF_W-1:0]             digest_word3
);

  localparam int unsigned W = shasmd_pkg::WORD_W;

  function automatic logic [W-1:0] rotr(input logic [W-1:0] v, input int unsigned n);
    return (v >> n) | (v << (W - n));
  endfunction

  logic [shasmd_pkg::HALF_W-1:0] secret_upper_r, secret_lower_r;
  logic [W-1:0] w_r   [16];
  logic [W-1:0] st_r  [8];
  logic [W-1:0] dig_r [8];

  logic [W-1:0] w_new, big0, big1, choose, major, sum1, sum2, ssig0, ssig1;

  // secret registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      secret_upper_r <= '0;
      secret_lower_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == shasmd_pkg::REG_SECRET_UPPER) begin
        secret_upper_r <= cfg_data;
      end
      if (cfg_index == shasmd_pkg::REG_SECRET_LOWER) begin
        secret_lower_r <= cfg_data;
      end
    end
  end

  always_comb begin
    ssig0  = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    ssig1  = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    w_new  = w_r[0] + ssig0 + w_r[9] + ssig1;
    big1   = rotr(st_r[4], 6) ^ rotr(st_r[4], 11) ^ rotr(st_r[4], 25);
    choose = (st_r[4] & st_r[5]) ^ (~st_r[4] & st_r[6]);
    sum1   = st_r[7] + big1 + choose + w_r[0] + shasmd_pkg::round_k(cmd.rnd);
    big0   = rotr(st_r[0], 2) ^ rotr(st_r[0], 13) ^ rotr(st_r[0], 22);
    major  = (st_r[0] & st_r[1]) ^ (st_r[0] & st_r[2]) ^ (st_r[1] & st_r[2]);
    sum2   = big0 + major;
  end

  // schedule window and working state
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w_r[0]  <= secret_upper_r[63:32];
      w_r[1]  <= secret_upper_r[31:0];
      w_r[2]  <= secret_lower_r[63:32];
      w_r[3]  <= secret_lower_r[31:0];
      w_r[4]  <= message_upper[63:32];
      w_r[5]  <= message_upper[31:0];
      w_r[6]  <= message_lower[63:32];
      w_r[7]  <= message_lower[31:0];
      w_r[8]  <= shasmd_pkg::PAD_ONE;
      for (int i = 9; i < 15; i++) begin
        w_r[i] <= shasmd_pkg::PAD_ZERO;
      end
      w_r[15] <= shasmd_pkg::PAD_LEN;
      for (int i = 0; i < 8; i++) begin
        st_r[i] <= shasmd_pkg::H_INIT[i];
      end
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= w_new;
      st_r[7] <= st_r[6];
      st_r[6] <= st_r[5];
      st_r[5] <= st_r[4];
      st_r[4] <= st_r[3] + sum1;
      st_r[3] <= st_r[2];
      st_r[2] <= st_r[1];
      st_r[1] <= st_r[0];
      st_r[0] <= sum1 + sum2;
    end
  end

  // final add into the output register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      for (int i = 0; i < 8; i++) begin
        dig_r[i] <= st_r[i] + shasmd_pkg::H_INIT[i];
      end
    end
  end

  assign digest_word0 = {dig_r[0], dig_r[1]};
  assign digest_word1 = {dig_r[2], dig_r[3]};
  assign digest_word2 = {dig_r[4], dig_r[5]};
  assign digest_word3 = {dig_r[6], dig_r[7]};

endmodule
`default_nettype wire

// ===== design/sha256_secret_message_digest_core.sv =====
// SHA-256 of one 256-bit string: a 128-bit secret from the configuration
// registers followed by a 128-bit message from the input transaction.
// Configuration: cfg_index 0 writes secret bits 127..64, index 1 writes
// bits 63..0; other indexes are dropped. cfg_ready is always high. Write
// only while no transaction is in flight.
// Input: in_valid/in_ready carry message_upper/message_lower. in_ready is
// high while the core is idle.
// Output: out_valid/out_ready carry the 256-bit digest as four 64-bit
// words, word0 holding H0:H1 in standard big-endian order.
// Operation: a load, then 64 rounds (one round a cycle through a single
// round unit, with the message schedule computed alongside from a
// 16-word shift window), then the final add into the output register; a
// new message is taken only once the previous one has had its final add.
// A new message is accepted while the previous digest still waits in the
// output register; if the receiver stalls, the core holds after the last
// round until the output register drains.
// Reset (synchronous, active low) clears the secret to zero, returns the
// controller to idle and drops any pending digest.
`default_nettype none
module sha256_secret_message_digest_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [shasmd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [shasmd_pkg::HALF_W-1:0]        cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [shasmd_pkg::HALF_W-1:0]        in_message_upper,
  input  wire logic [shasmd_pkg::HALF_W-1:0]        in_message_lower,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [shasmd_pkg::HALF_W-1:0]             out_digest_word0,
  output logic [shasmd_pkg::HALF_W-1:0]             out_digest_word1,
  output logic [shasmd_pkg::HALF_W-1:0]             out_digest_word2,
  output logic [shasmd_pkg::HALF_W-1:0]             out_digest_word3
);

  shasmd_pkg::cmd_t cmd;

  // configuration writes are always accepted and registered
  assign cfg_ready = 1'b1;

  shasmd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  shasmd_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .cfg_we        (cfg_valid & cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .message_upper (in_message_upper),
    .message_lower (in_message_lower),
    .digest_word0  (out_digest_word0),
    .digest_word1  (out_digest_word1),
    .digest_word2  (out_digest_word2),
    .digest_word3  (out_digest_word3)
  );

endmodule
`default_nettype wire
